// ===== sv/ssrs_pkg.sv =====
`default_nettype none

package ssrs_pkg;

  localparam int MAX_POSITIONS = 4;
  localparam int IDX_W         = 2;
  localparam int ANGLE_W       = 13;
  localparam int OFFSET_W      = 11;
  localparam int TIME_W        = 16;
  localparam int RATE_W        = 15;
  localparam int PHASE_W       = 3;
  localparam int COUNT_W       = 3;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 16;

  localparam logic [PHASE_W-1:0] PH_READY  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_MOVING = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SETTLE = 3'd2;
  localparam logic [PHASE_W-1:0] PH_RANGE  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_POST   = 3'd4;

  localparam logic [TIME_W-1:0] RANGE_POLL_MS = 16'd50;
  localparam logic [TIME_W-1:0] POST_RANGE_MS = 16'd10;

  localparam logic [CFG_INDEX_W-1:0] REG_POSITION_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POSITION_A     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_POSITION_B     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_POSITION_C     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_POSITION_D     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_OFFSET    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_DELAY   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_MOVE_RATE      = 3'd7;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_POSITIONS);

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic [IDX_W-1:0]          index_t;
  typedef logic [TIME_W-1:0]         time_t;
  typedef logic [PHASE_W-1:0]        phase_t;

  typedef struct packed {
    logic [COUNT_W-1:0]               position_count;
    angle_t [MAX_POSITIONS-1:0]       position;
    logic signed [OFFSET_W-1:0]       zero_offset;
    time_t                            settle_delay_ms;
    logic [RATE_W-1:0]                move_rate;
  } cfg_t;

  typedef struct packed {
    logic stop_req;
    logic start_req;
    logic scan_req;
    logic range_busy;
  } item_t;

  typedef struct packed {
    logic   servo_move;
    angle_t servo_target;
    time_t  move_time_ms;
    logic   range_start;
    angle_t joint_angle;
    phase_t phase_now;
  } result_t;

  typedef struct packed {
    index_t index;
    angle_t target;
    time_t  move_time;
  } move_t;

endpackage

`default_nettype wire

// ===== sv/ssrs_move.sv =====
`default_nettype none

module ssrs_move (
  input  var ssrs_pkg::cfg_t   cfg,
  input  var logic             mode,
  input  var ssrs_pkg::index_t base_index,
  input  var ssrs_pkg::angle_t current_angle,
  output var ssrs_pkg::move_t  mv
);
  import ssrs_pkg::*;

  logic [COUNT_W-1:0]           count_used;
  logic [COUNT_W-1:0]           index_inc;
  index_t                       index_new;
  logic signed [ANGLE_W:0]      target_sum;
  angle_t                       target;
  logic signed [ANGLE_W:0]      diff;
  logic [ANGLE_W-1:0]           magnitude;
  logic [ANGLE_W+RATE_W-1:0]    product;

  always_comb begin
    count_used = (cfg.position_count > COUNT_LIMIT) ? COUNT_LIMIT : cfg.position_count;
    index_inc  = {1'b0, base_index} + COUNT_W'(1);
    if (!mode) begin
      index_new = '0;
    end else if (index_inc >= count_used) begin
      index_new = '0;
    end else begin
      index_new = index_inc[IDX_W-1:0];
    end

    target_sum = {cfg.position[index_new][ANGLE_W-1], cfg.position[index_new]}
               + {{(ANGLE_W+1-OFFSET_W){cfg.zero_offset[OFFSET_W-1]}}, cfg.zero_offset};
    if (target_sum[ANGLE_W] != target_sum[ANGLE_W-1]) begin
      target = target_sum[ANGLE_W] ? {1'b1, {(ANGLE_W-1){1'b0}}}
                                   : {1'b0, {(ANGLE_W-1){1'b1}}};
    end else begin
      target = target_sum[ANGLE_W-1:0];
    end

    diff      = {current_angle[ANGLE_W-1], current_angle} - {target[ANGLE_W-1], target};
    magnitude = diff[ANGLE_W] ? ANGLE_W'(-diff) : diff[ANGLE_W-1:0];
    product   = magnitude * cfg.move_rate;

    // The largest product shifted down by 12 stays below 65536, so no clamp is needed.
    mv.index     = index_new;
    mv.target    = target;
    mv.move_time = product[ANGLE_W+RATE_W-1:12];
  end

endmodule

`default_nettype wire

// ===== sv/ssrs_core.sv =====
`default_nettype none

module ssrs_core (
  input  var logic              clk,
  input  var logic              rst,
  input  var logic              advance,
  input  var ssrs_pkg::item_t   item,
  input  var ssrs_pkg::cfg_t    cfg,
  output var ssrs_pkg::result_t result
);
  import ssrs_pkg::*;

  phase_t phase;
  phase_t phase_next;
  index_t table_index;
  index_t table_index_next;
  logic   scan_mode;
  logic   scan_mode_next;
  angle_t servo_angle;
  angle_t servo_angle_next;
  time_t  wait_left;
  time_t  wait_left_next;

  phase_t phase_mid;
  time_t  wait_mid;
  time_t  delay;
  logic   start_go;
  logic   mode_sel;
  index_t index_sel;
  logic   moved;
  logic   ranged;
  move_t  mv;

  ssrs_move u_move (
    .cfg           (cfg),
    .mode          (mode_sel),
    .base_index    (index_sel),
    .current_angle (servo_angle),
    .mv            (mv)
  );

  always_comb begin
    phase_mid = item.stop_req ? PH_READY : phase;
    start_go  = item.start_req
              && !((item.scan_req == scan_mode) && (phase_mid != PH_READY));
    mode_sel  = start_go ? item.scan_req : scan_mode;
    index_sel = start_go ? '0 : table_index;

    scan_mode_next   = scan_mode;
    table_index_next = table_index;
    servo_angle_next = servo_angle;
    wait_mid         = wait_left;
    moved            = 1'b0;
    ranged           = 1'b0;
    delay            = RANGE_POLL_MS;

    if (start_go) begin
      scan_mode_next   = item.scan_req;
      table_index_next = mv.index;
      servo_angle_next = mv.target;
      phase_mid        = PH_MOVING;
      wait_mid         = mv.move_time;
      moved            = 1'b1;
    end

    phase_next = phase_mid;
    if (wait_mid != '0) begin
      wait_left_next = wait_mid - TIME_W'(1);
    end else begin
      unique case (phase_mid)
        PH_MOVING: begin
          phase_next = PH_SETTLE;
          delay      = cfg.settle_delay_ms;
        end
        PH_SETTLE: begin
          phase_next = PH_RANGE;
          ranged     = 1'b1;
          delay      = '0;
        end
        PH_RANGE: begin
          if (!item.range_busy) begin
            phase_next = PH_POST;
            delay      = POST_RANGE_MS;
          end
        end
        PH_POST: begin
          phase_next       = PH_MOVING;
          table_index_next = mv.index;
          servo_angle_next = mv.target;
          moved            = 1'b1;
          delay            = mv.move_time;
        end
        default: begin
          delay = RANGE_POLL_MS;
        end
      endcase
      wait_left_next = (delay != '0) ? (delay - TIME_W'(1)) : '0;
    end

    result.servo_move   = moved;
    result.servo_target = moved ? mv.target : '0;
    result.move_time_ms = moved ? mv.move_time : '0;
    result.range_start  = ranged;
    result.joint_angle  = cfg.position[table_index_next];
    result.phase_now    = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_READY;
      table_index <= '0;
      scan_mode   <= 1'b0;
      servo_angle <= '0;
      wait_left   <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      table_index <= table_index_next;
      scan_mode   <= scan_mode_next;
      servo_angle <= servo_angle_next;
      wait_left   <= wait_left_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/servo_scan_range_sequencer.sv =====
// Channel    Direction  Content
// s_axis     in         one millisecond tick with stop, start, scan and busy flags
// m_axis     out        one result per tick: move command, range start, angle, phase
// cfg        in         register writes, one per cycle, no read-back
//
// One tick is accepted per cycle while the output does not stall; the tick is registered,
// run through the phase logic and the move multiplier combinationally, and the result is
// held in an output register, from which it is presented.
// Reset returns the phase machine, the configuration and the valid flags to their defaults.
// A stalled output holds the result register and then the input register fills.
`default_nettype none

module servo_scan_range_sequencer (
  input  var logic                                clk,
  input  var logic                                rst,
  input  var logic                                s_axis_tvalid,
  output var logic                                s_axis_tready,
  // stop_req, start_req, scan_req, range_busy, then zero padding
  input  var logic [7:0]                          s_axis_tdata,
  output var logic                                m_axis_tvalid,
  input  var logic                                m_axis_tready,
  // servo_move, servo_target, move_time_ms, range_start, joint_angle, phase_now, zero pad
  output var logic [47:0]                         m_axis_tdata,
  input  var logic                                cfg_wr_en,
  input  var logic [ssrs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  var logic [ssrs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ssrs_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    advance;
  result_t result_comb;
  result_t result_q;
  logic    out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.position_count  <= COUNT_W'(1);
      cfg.position        <= '0;
      cfg.zero_offset     <= '0;
      cfg.settle_delay_ms <= TIME_W'(1000);
      cfg.move_rate       <= RATE_W'(1280);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_POSITION_COUNT: cfg.position_count  <= cfg_data[COUNT_W-1:0];
        REG_POSITION_A:     cfg.position[0]     <= cfg_data[ANGLE_W-1:0];
        REG_POSITION_B:     cfg.position[1]     <= cfg_data[ANGLE_W-1:0];
        REG_POSITION_C:     cfg.position[2]     <= cfg_data[ANGLE_W-1:0];
        REG_POSITION_D:     cfg.position[3]     <= cfg_data[ANGLE_W-1:0];
        REG_ZERO_OFFSET:    cfg.zero_offset     <= cfg_data[OFFSET_W-1:0];
        REG_SETTLE_DELAY:   cfg.settle_delay_ms <= cfg_data[TIME_W-1:0];
        REG_MOVE_RATE:      cfg.move_rate       <= cfg_data[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.stop_req   <= s_axis_tdata[0];
      in_item.start_req  <= s_axis_tdata[1];
      in_item.scan_req   <= s_axis_tdata[2];
      in_item.range_busy <= s_axis_tdata[3];
    end
  end

  ssrs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .cfg     (cfg),
    .result  (result_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result_comb;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0,
                          result_q.phase_now,
                          result_q.joint_angle,
                          result_q.range_start,
                          result_q.move_time_ms,
                          result_q.servo_target,
                          result_q.servo_move};

`ifndef SYNTHESIS
  // A range measurement is only started on entry to the ranging phase.
  a_range_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_q.range_start) |-> (result_q.phase_now == PH_RANGE))
    else $error("range start outside the ranging phase");

  // A move leaves the sequencer moving, or settling when the move takes no time.
  a_move_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_q.servo_move)
      |-> (result_q.phase_now == PH_MOVING || result_q.phase_now == PH_SETTLE))
    else $error("move command with an unexpected phase");

  // Without a move the command fields are zero.
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result_q.servo_move)
      |-> (result_q.servo_target == '0 && result_q.move_time_ms == '0))
    else $error("command fields set without a move");

  // A move and a range start never fall on the same tick.
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(result_q.servo_move && result_q.range_start))
    else $error("move and range start on the same tick");
`endif

endmodule

`default_nettype wire
